// ===== src/sysexr_pkg.sv =====
// shared constants, types and codes for the sysex reassembler and command decoder
package sysexr_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int MAX_RESULTS     = 64;
  localparam int HEADER_LEN      = 6;
  localparam int CMD_POS         = 6;
  localparam int TEXT_POS        = 7;
  localparam int SHADOW_LEN      = 8;
  localparam int PACKET_BYTES    = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 1'd1;

  localparam logic [47:0] HEADER_RESET = 48'hF000_2029_0218;
  localparam logic [7:0]  LIMIT_RESET  = 8'd5;

  localparam logic [3:0] CIN_CONTINUE = 4'h4;
  localparam logic [3:0] CIN_END1     = 4'h5;
  localparam logic [3:0] CIN_END2     = 4'h6;
  localparam logic [3:0] CIN_END3     = 4'h7;

  localparam logic [7:0] CMD_LAYOUT    = 8'h22;
  localparam logic [7:0] CMD_CHALLENGE = 8'h40;
  localparam logic [7:0] CMD_TEXT      = 8'h14;

  typedef enum logic [1:0] {
    KIND_UNKNOWN   = 2'd0,
    KIND_LAYOUT    = 2'd1,
    KIND_CHALLENGE = 2'd2,
    KIND_TEXT      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_DECODE,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic       text;
    logic [7:0] layout;
  } decode_t;

endpackage

// ===== src/sysexr_in_if.sv =====
// packet channel carrying one usb-midi sysex event per transaction
interface sysexr_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] code_index;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;

  modport source (output valid, code_index, first_byte, second_byte, third_byte, input ready);
  modport sink (input valid, code_index, first_byte, second_byte, third_byte, output ready);
endinterface

// ===== src/sysexr_out_if.sv =====
// result channel carrying one decoded result per transaction
interface sysexr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload;
  logic       last;

  modport source (output valid, kind, payload, last, input ready);
  modport sink (input valid, kind, payload, last, output ready);
endinterface

// ===== src/sysex_reassembler_command_decoder.sv =====
// top level: sysex packet reassembly into the message store and command decoding
// packets are accepted only when idle, so none is taken until the last one is done;
// the 1 to 3 bytes go to the store one per cycle; an ending packet then passes the decode
// state, and each text byte is read from the store; every result waits for a free output
// reset: synchronous; clears the stored length, the layout and the output valid, and loads
// the header and layout limit registers with their defaults; the store needs no clearing
module sysex_reassembler_command_decoder #(
  parameter int STORE_DEPTH = sysexr_pkg::STORE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  sysexr_in_if.sink                         packet,
  sysexr_out_if.source                      result,
  input  logic                              cfg_write,
  input  logic [sysexr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sysexr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sysexr_pkg::*;

  localparam int AW        = $clog2(STORE_DEPTH);
  localparam int LW        = $clog2(STORE_DEPTH + 1);
  localparam int CW        = $clog2(MAX_RESULTS + 1);
  localparam int FULL_MARK = STORE_DEPTH - PACKET_BYTES;
  localparam int LIM_LEN   = MAX_RESULTS + TEXT_POS;

  state_t            state;
  state_t            state_next;
  logic [CFG_DATA_W-1:0] header_bytes;
  logic [7:0]        layout_limit;
  logic [7:0]        layout_now;
  logic [LW-1:0]     length;
  logic [3:0]        code;
  logic [7:0]        pkt_byte [PACKET_BYTES];
  logic [1:0]        byte_cnt;
  logic [1:0]        last_cnt;
  logic [7:0]        head [SHADOW_LEN];
  logic [CW-1:0]     left;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        rd_data;
  logic              out_valid;
  kind_t             out_kind;
  logic [7:0]        out_payload;
  logic              out_last;

  decode_t           dec;
  logic              accept;
  logic              code_ok;
  logic              out_free;
  logic              long_enough;
  logic [7:0]        wr_byte;
  logic              wr_en;
  logic              rd_en;
  logic              load_out;
  kind_t             out_kind_next;
  logic [7:0]        out_payload_next;
  logic              out_last_next;
  logic              start_pkt;
  logic              drop;
  logic              set_layout;
  logic              start_emit;
  logic              finish;

  assign accept      = packet.valid && packet.ready;
  assign code_ok     = packet.code_index inside {CIN_CONTINUE, CIN_END1, CIN_END2, CIN_END3};
  assign out_free    = !out_valid || result.ready;
  assign long_enough = length > LW'(TEXT_POS);
  assign wr_byte     = pkt_byte[byte_cnt];

  assign packet.ready   = (state == S_IDLE);
  assign result.valid   = out_valid;
  assign result.kind    = out_kind;
  assign result.payload = out_payload;
  assign result.last    = out_last;

  sysexr_mem #(
    .DEPTH (STORE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (length[AW-1:0]),
    .wr_data (wr_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sysexr_decode u_decode (
    .head         (head),
    .header_bytes (header_bytes),
    .layout_limit (layout_limit),
    .layout_now   (layout_now),
    .long_enough  (long_enough),
    .dec          (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    load_out         = 1'b0;
    out_kind_next    = KIND_UNKNOWN;
    out_payload_next = '0;
    out_last_next    = 1'b0;
    start_pkt        = 1'b0;
    drop             = 1'b0;
    set_layout       = 1'b0;
    start_emit       = 1'b0;
    finish           = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && code_ok) begin
          if (length >= LW'(FULL_MARK)) begin
            drop = 1'b1;
          end else begin
            start_pkt  = 1'b1;
            state_next = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        wr_en = 1'b1;
        if (byte_cnt == last_cnt) begin
          state_next = (code == CIN_CONTINUE) ? S_IDLE : S_DECODE;
        end
      end
      S_DECODE: begin
        if (dec.text) begin
          start_emit = 1'b1;
          state_next = S_EMIT_RD;
        end else if (out_free) begin
          load_out      = 1'b1;
          out_kind_next = dec.kind;
          out_last_next = 1'b1;
          if (dec.kind == KIND_LAYOUT) begin
            out_payload_next = dec.layout;
            set_layout       = 1'b1;
          end
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        rd_en      = 1'b1;
        state_next = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_kind_next = KIND_TEXT;
          if (left == CW'(1)) begin
            out_last_next = 1'b1;
            finish        = 1'b1;
            state_next    = S_IDLE;
          end else begin
            out_payload_next = rd_data;
            state_next       = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HEADER_RESET;
      layout_limit <= LIMIT_RESET;
      layout_now   <= '0;
      length       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_HEADER: header_bytes <= cfg_data;
          REG_LIMIT:  layout_limit <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (drop || finish) begin
        length <= '0;
      end else if (wr_en) begin
        length <= length + LW'(1);
      end
      if (set_layout) begin
        layout_now <= dec.layout;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_pkt) begin
      code        <= packet.code_index;
      pkt_byte[0] <= packet.first_byte;
      pkt_byte[1] <= packet.second_byte;
      pkt_byte[2] <= packet.third_byte;
      byte_cnt    <= '0;
      case (packet.code_index)
        CIN_END1: last_cnt <= 2'd0;
        CIN_END2: last_cnt <= 2'd1;
        default:  last_cnt <= 2'd2;
      endcase
    end
    if (wr_en) begin
      byte_cnt <= byte_cnt + 2'd1;
      if (length < LW'(SHADOW_LEN)) begin
        head[length[2:0]] <= wr_byte;
      end
    end
    if (start_emit) begin
      rd_addr <= AW'(TEXT_POS);
      left    <= (int'(length) > LIM_LEN) ? CW'(MAX_RESULTS) : CW'(length - LW'(TEXT_POS));
    end else if (load_out && state == S_EMIT_OUT) begin
      rd_addr <= rd_addr + AW'(1);
      left    <= left - CW'(1);
    end
    if (load_out) begin
      out_kind    <= out_kind_next;
      out_payload <= out_payload_next;
      out_last    <= out_last_next;
    end
  end

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LW'(STORE_DEPTH))
    else $error("stored length beyond store depth");

  a_ignored_code: assert property (@(posedge clk) disable iff (rst)
    accept && !code_ok |=> $stable(length))
    else $error("ignored packet changed stored length");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    load_out && out_last_next |=> state == S_IDLE)
    else $error("final result did not return to idle");

  a_emit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT_OUT |-> left != '0)
    else $error("text emission with no bytes left");

endmodule

// ===== src/sysexr_mem.sv =====
// message store: single write port, single read port with registered read data
module sysexr_mem #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sysexr_decode.sv =====
// header check and command classification of a completed message
module sysexr_decode (
  input  logic [7:0]                        head [sysexr_pkg::SHADOW_LEN],
  input  logic [sysexr_pkg::CFG_DATA_W-1:0] header_bytes,
  input  logic [7:0]                        layout_limit,
  input  logic [7:0]                        layout_now,
  input  logic                              long_enough,
  output sysexr_pkg::decode_t               dec
);
  import sysexr_pkg::*;

  logic match;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < HEADER_LEN; i++) begin
      if (head[i] != header_bytes[(HEADER_LEN-1-i)*8 +: 8]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    dec.kind   = KIND_UNKNOWN;
    dec.text   = 1'b0;
    dec.layout = (head[TEXT_POS] <= layout_limit) ? head[TEXT_POS] : layout_now;
    if (long_enough && match) begin
      case (head[CMD_POS])
        CMD_LAYOUT: begin
          dec.kind = KIND_LAYOUT;
        end
        CMD_CHALLENGE: begin
          dec.kind = KIND_CHALLENGE;
        end
        CMD_TEXT: begin
          dec.kind = KIND_TEXT;
          dec.text = 1'b1;
        end
        default: begin
          dec.kind = KIND_UNKNOWN;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/sysex_decode_checker.sv =====
// checker for the sysex reassembler: predicts decoded results per packet and compares them
`timescale 1ns / 1ps

module sysex_decode_checker #(
  parameter int STORE_DEPTH = sysexr_pkg::STORE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  sysexr_in_if                              pkt,
  sysexr_out_if                             res,
  input  logic                              cfg_write,
  input  logic [sysexr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sysexr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                failures,
  output int                                pending
);
  import sysexr_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic       last;
  } decoded_t;

  decoded_t    expected_results[$];
  logic [7:0]  message_bytes [STORE_DEPTH];
  int          msg_len;
  logic [7:0]  layout_now;
  logic [7:0]  layout_cap;
  logic [47:0] header_want;
  int          mismatches = 0;

  function automatic void emit(input kind_t k, input logic [7:0] p, input logic l);
    expected_results.push_back({k, p, l});
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    if (msg_len < STORE_DEPTH) begin
      message_bytes[msg_len] = b;
      msg_len++;
    end
  endfunction

  function automatic logic header_ok();
    for (int i = 0; i < HEADER_LEN; i++) begin
      if (message_bytes[i] != header_want[47 - 8*i -: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void decode_message(input int len);
    int count;
    if (len <= TEXT_POS || len > STORE_DEPTH || !header_ok()) begin
      emit(KIND_UNKNOWN, 8'd0, 1'b1);
      return;
    end
    case (message_bytes[CMD_POS])
      CMD_LAYOUT: begin
        if (message_bytes[TEXT_POS] <= layout_cap) layout_now = message_bytes[TEXT_POS];
        emit(KIND_LAYOUT, layout_now, 1'b1);
      end
      CMD_CHALLENGE: begin
        emit(KIND_CHALLENGE, 8'd0, 1'b1);
      end
      CMD_TEXT: begin
        count = len - TEXT_POS;
        message_bytes[len - 1] = 8'd0;
        if (count > MAX_RESULTS) count = MAX_RESULTS;
        for (int i = 0; i + 1 < count; i++) emit(KIND_TEXT, message_bytes[TEXT_POS + i], 1'b0);
        emit(KIND_TEXT, 8'd0, 1'b1);
      end
      default: begin
        emit(KIND_UNKNOWN, 8'd0, 1'b1);
      end
    endcase
  endfunction

  function automatic void absorb_packet(input logic [3:0] code, input logic [7:0] b0,
                                        input logic [7:0] b1, input logic [7:0] b2);
    if (code < CIN_CONTINUE || code > CIN_END3) return;
    // nearly full store: empty it and drop the packet
    if (msg_len >= STORE_DEPTH - PACKET_BYTES) begin
      msg_len = 0;
      return;
    end
    store_byte(b0);
    if (code != CIN_END1) store_byte(b1);
    if (code == CIN_CONTINUE || code == CIN_END3) store_byte(b2);
    if (code == CIN_CONTINUE) return;
    decode_message(msg_len);
    msg_len = 0;
  endfunction

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      expected_results.delete();
      msg_len     = 0;
      layout_now  = 8'd0;
      layout_cap  = LIMIT_RESET;
      header_want = HEADER_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_HEADER: header_want = cfg_data;
          REG_LIMIT:  layout_cap = cfg_data[7:0];
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d payload %0d last %0d",
                 res.kind, res.payload, res.last);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (res.kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, res.kind);
            mismatches++;
          end
          if (res.payload !== want.payload) begin
            $error("payload mismatch: expected %0d, actual %0d", want.payload, res.payload);
            mismatches++;
          end
          if (res.last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, res.last);
            mismatches++;
          end
        end
      end
      if (pkt.valid && pkt.ready) begin
        absorb_packet(pkt.code_index, pkt.first_byte, pkt.second_byte, pkt.third_byte);
      end
    end
    failures <= mismatches;
    pending  <= expected_results.size();
  end

endmodule

// ===== tb/sv/sysex_reassembler_command_decoder_test.sv =====
// testbench top for the sysex reassembler: packet stimulus, config phases and verdict
`timescale 1ns / 1ps

module sysex_reassembler_command_decoder_test;
  import sysexr_pkg::*;

  localparam int STORE_DEPTH    = STORE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    pending;

  logic [47:0] cur_header;
  logic [7:0]  cur_limit;
  int          src_idle;
  int          sink_idle;
  int          packets_sent = 0;
  int          quiet_cycles = 0;
  logic        hold_toggle = 1'b0;
  logic [7:0]  outgoing[$];

  sysexr_in_if  pkt_ch ();
  sysexr_out_if res_ch ();

  sysex_reassembler_command_decoder #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .packet    (pkt_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sysex_decode_checker #(.STORE_DEPTH(STORE_DEPTH)) decode_watch (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt_ch),
    .res       (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result receiver with random stalls and a long hold on request
  initial begin
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_packet(input logic [3:0] code, input logic [7:0] b0,
                             input logic [7:0] b1, input logic [7:0] b2);
    if ($urandom_range(99) < src_idle) begin
      pkt_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    pkt_ch.valid       <= 1'b1;
    pkt_ch.code_index  <= code;
    pkt_ch.first_byte  <= b0;
    pkt_ch.second_byte <= b1;
    pkt_ch.third_byte  <= b2;
    @(posedge clk);
    while (!pkt_ch.ready) @(posedge clk);
    if (code >= CIN_CONTINUE && code <= CIN_END3) packets_sent++;
  endtask

  function automatic void load_header(input logic [47:0] hdr);
    outgoing.delete();
    for (int i = 0; i < HEADER_LEN; i++) outgoing.push_back(hdr[47 - 8*i -: 8]);
  endfunction

  function automatic void add_random_bytes(input int n);
    for (int i = 0; i < n; i++) outgoing.push_back(8'($urandom));
  endfunction

  // split the queued message into continue packets and one ending packet
  task automatic send_outgoing();
    logic [7:0] chunk [PACKET_BYTES];
    logic [3:0] code;
    int         n;
    while (outgoing.size() > PACKET_BYTES) begin
      for (int i = 0; i < PACKET_BYTES; i++) chunk[i] = outgoing.pop_front();
      send_packet(CIN_CONTINUE, chunk[0], chunk[1], chunk[2]);
    end
    n = outgoing.size();
    for (int i = 0; i < PACKET_BYTES; i++) chunk[i] = (i < n) ? outgoing.pop_front() : 8'($urandom);
    code = (n == 1) ? CIN_END1 : (n == 2) ? CIN_END2 : CIN_END3;
    send_packet(code, chunk[0], chunk[1], chunk[2]);
  endtask

  task automatic send_random_message();
    int         pick;
    int         count;
    logic [7:0] value;
    pick = $urandom_range(99);
    load_header(cur_header);
    if (pick < 10) begin
      // short message
      outgoing.push_back(8'($urandom));
      count = $urandom_range(1, TEXT_POS);
      while (outgoing.size() > count) void'(outgoing.pop_back());
      send_outgoing();
    end else if (pick < 25) begin
      case ($urandom_range(3))
        0:       value = cur_limit;
        1:       value = cur_limit + 8'd1;
        2:       value = 8'($urandom_range(cur_limit));
        default: value = 8'($urandom);
      endcase
      outgoing.push_back(CMD_LAYOUT);
      outgoing.push_back(value);
      add_random_bytes($urandom_range(0, 6));
      send_outgoing();
    end else if (pick < 35) begin
      outgoing.push_back(CMD_CHALLENGE);
      add_random_bytes($urandom_range(1, 10));
      send_outgoing();
    end else if (pick < 70) begin
      outgoing.push_back(CMD_TEXT);
      add_random_bytes(($urandom_range(9) == 0) ? $urandom_range(13, 56) : $urandom_range(1, 12));
      send_outgoing();
    end else if (pick < 80) begin
      // one header byte corrupted
      count = $urandom_range(HEADER_LEN - 1);
      outgoing[count] = outgoing[count] ^ 8'($urandom_range(1, 255));
      case ($urandom_range(2))
        0:       outgoing.push_back(CMD_LAYOUT);
        1:       outgoing.push_back(CMD_CHALLENGE);
        default: outgoing.push_back(CMD_TEXT);
      endcase
      add_random_bytes($urandom_range(1, 8));
      send_outgoing();
    end else if (pick < 88) begin
      do value = 8'($urandom);
      while (value == CMD_LAYOUT || value == CMD_CHALLENGE || value == CMD_TEXT);
      outgoing.push_back(value);
      add_random_bytes($urandom_range(1, 6));
      send_outgoing();
    end else if (pick < 94) begin
      // runs past the store and gets dropped
      outgoing.push_back(CMD_TEXT);
      add_random_bytes($urandom_range(57, 80));
      send_outgoing();
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_packet(4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // close any partial message, then wait for the block to go quiet
  task automatic finish_phase();
    send_packet(CIN_END1, 8'($urandom), 8'($urandom), 8'($urandom));
    pkt_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [47:0] hdr, input logic [7:0] lim);
    cur_header = hdr;
    cur_limit  = lim;
    cfg_write <= 1'b1;
    cfg_index <= REG_HEADER;
    cfg_data  <= hdr;
    @(posedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data  <= {8'($urandom), 32'($urandom), lim};
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(input int items);
    int goal;
    goal = packets_sent + items;
    while (packets_sent < goal) send_random_message();
    finish_phase();
  endtask

  task automatic run_directed();
    // layout inside the limit, then above it
    load_header(cur_header);
    outgoing.push_back(CMD_LAYOUT);
    outgoing.push_back(8'd3);
    send_outgoing();
    load_header(cur_header);
    outgoing.push_back(CMD_LAYOUT);
    outgoing.push_back(8'hFF);
    outgoing.push_back(8'h00);
    send_outgoing();
    load_header(cur_header);
    outgoing.push_back(CMD_CHALLENGE);
    outgoing.push_back(8'h7F);
    send_outgoing();
    // text, final byte becomes the terminator
    load_header(cur_header);
    outgoing.push_back(CMD_TEXT);
    outgoing.push_back(8'h00);
    outgoing.push_back(8'hFF);
    outgoing.push_back(8'h80);
    outgoing.push_back(8'h41);
    send_outgoing();
    // text of terminator only
    load_header(cur_header);
    outgoing.push_back(CMD_TEXT);
    outgoing.push_back(8'h55);
    send_outgoing();
    // short messages
    send_packet(CIN_END1, 8'hF0, 8'hFF, 8'h00);
    send_packet(CIN_END3, 8'h00, 8'hFF, 8'h80);
    // header mismatch
    load_header(cur_header ^ 48'h1);
    outgoing.push_back(CMD_CHALLENGE);
    outgoing.push_back(8'h00);
    send_outgoing();
    // unknown command
    load_header(cur_header);
    outgoing.push_back(8'h7F);
    outgoing.push_back(8'h01);
    send_outgoing();
    // code indices outside the sysex range
    send_packet(4'h0, 8'hFF, 8'hFF, 8'hFF);
    send_packet(4'hF, 8'h00, 8'h00, 8'h00);
  endtask

  initial begin
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = REG_HEADER;
    cfg_data           = '0;
    pkt_ch.valid       = 1'b0;
    pkt_ch.code_index  = 4'h0;
    pkt_ch.first_byte  = 8'h00;
    pkt_ch.second_byte = 8'h00;
    pkt_ch.third_byte  = 8'h00;
    cur_header         = HEADER_RESET;
    cur_limit          = LIMIT_RESET;
    src_idle           = 15;
    sink_idle          = 63;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    finish_phase();

    configure({16'($urandom), 32'($urandom)}, 8'd0);
    run_phase(100);

    src_idle  = 63;
    sink_idle = 15;
    configure(48'hFFFF_FFFF_FFFF, 8'd255);
    run_phase(100);

    // long receiver hold while long texts keep arriving
    src_idle  = 0;
    sink_idle = 0;
    configure(48'h0, 8'($urandom));
    hold_toggle <= ~hold_toggle;
    repeat (4) begin
      load_header(cur_header);
      outgoing.push_back(CMD_TEXT);
      add_random_bytes(40);
      send_outgoing();
    end
    run_phase(90);

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
